FILE: rtl/mec_pkg.sv
// ----------------------------------------------------------------------------
// mec_pkg
// Shared types and constants for the multiset equality counter: transaction
// kinds, controller states and the default table geometry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mec_pkg;

    // table geometry and field widths
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int VALUE_W         = 32;
    localparam int COUNT_W         = 8;
    localparam int KIND_W          = 2;

    // transaction kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CHECK  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    // count of a freshly inserted entry after one add or one remove
    localparam logic [COUNT_W-1:0] COUNT_ONE   = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_MINUS = {COUNT_W{1'b1}};

endpackage

`default_nettype wire

FILE: rtl/multiset_equality_counter_top.sv
// ----------------------------------------------------------------------------
// multiset_equality_counter_top
// Tallies values of two sequences in a table of distinct values with 8-bit
// net counts and, on a check transaction, reports whether all counts are zero.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; kind 0 adds
// value, kind 1 removes it, kind 2 checks and clears, kind 3 is dropped at once.
// Only a check produces a result: done pulses for one cycle with equal and
// overflow, and the receiver must take it then. Every add, remove or check
// transaction scans the used entries of one single-port-read table memory,
// one entry per cycle, and busy stays high until the scan ends. A distinct
// value that arrives while the table is full is dropped and sets a sticky
// overflow flag that the next check reports and clears. No clearing pass is
// needed after reset: entries beyond the fill count are never read.
`timescale 1ns / 1ps
`default_nettype none

module multiset_equality_counter_top #(
    parameter int TABLE_DEPTH = mec_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [mec_pkg::KIND_W-1:0]         kind,
    input  wire logic signed [mec_pkg::VALUE_W-1:0] value,
    output logic                                    done,
    output logic                                    equal,
    output logic                                    overflow
);

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = mec_pkg::VALUE_W + mec_pkg::COUNT_W;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_DEPTH);

    // table memory: {value, count} per entry
    logic [ENTRY_W-1:0] entry_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;

    // control and payload registers
    mec_pkg::state_t             state_reg, state_next;
    mec_pkg::kind_t              kind_reg, kind_next;
    logic [mec_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]            rd_idx_reg, rd_idx_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]            pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]            used_reg, used_next;
    logic                        ovf_seen_reg, ovf_seen_next;
    logic                        done_reg, done_next;
    logic                        equal_reg, equal_next;
    logic                        ovf_out_reg, ovf_out_next;

    // scan datapath
    logic [mec_pkg::VALUE_W-1:0] rd_value;
    logic [mec_pkg::COUNT_W-1:0] rd_count;
    logic [mec_pkg::COUNT_W-1:0] upd_count;
    logic [mec_pkg::COUNT_W-1:0] new_count;
    logic                        issue;
    logic                        hit;
    logic                        scan_end;
    logic                        is_check;

    assign rd_value  = rd_data_reg[ENTRY_W-1:mec_pkg::COUNT_W];
    assign rd_count  = rd_data_reg[mec_pkg::COUNT_W-1:0];
    assign is_check  = (kind_reg == mec_pkg::KIND_CHECK);
    assign issue     = (rd_idx_reg < used_reg);
    assign scan_end  = !pend_valid_reg && !issue;
    assign hit       = pend_valid_reg &&
                       (is_check ? (rd_count != '0) : (rd_value == value_reg));
    assign upd_count = (kind_reg == mec_pkg::KIND_ADD) ?
                       mec_pkg::COUNT_W'(rd_count + mec_pkg::COUNT_ONE) :
                       mec_pkg::COUNT_W'(rd_count - mec_pkg::COUNT_ONE);
    assign new_count = (kind_reg == mec_pkg::KIND_ADD) ?
                       mec_pkg::COUNT_ONE : mec_pkg::COUNT_MINUS;

    // table memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= entry_mem[mem_raddr];
    end

    // next state, memory control and result
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        value_next      = value_reg;
        rd_idx_next     = rd_idx_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        used_next       = used_reg;
        ovf_seen_next   = ovf_seen_reg;
        done_next       = 1'b0;
        equal_next      = equal_reg;
        ovf_out_next    = ovf_out_reg;
        mem_we          = 1'b0;
        mem_waddr       = pend_idx_reg;
        mem_wdata       = {value_reg, upd_count};
        mem_raddr       = rd_idx_reg[IDX_W-1:0];

        unique case (state_reg)
            mec_pkg::ST_IDLE:
            begin
                if (start && (kind != mec_pkg::KIND_NONE))
                begin
                    kind_next   = mec_pkg::kind_t'(kind);
                    value_next  = value;
                    rd_idx_next = '0;
                    state_next  = mec_pkg::ST_SCAN;
                end
            end
            mec_pkg::ST_SCAN:
            begin
                // one read per cycle, compared in the next cycle
                pend_valid_next = issue;
                pend_idx_next   = rd_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    rd_idx_next = CNT_W'(rd_idx_reg + 1'b1);
                end
                if (is_check)
                begin
                    if (hit || scan_end)
                    begin
                        done_next     = 1'b1;
                        equal_next    = !hit && !ovf_seen_reg;
                        ovf_out_next  = ovf_seen_reg;
                        used_next     = '0;
                        ovf_seen_next = 1'b0;
                        state_next    = mec_pkg::ST_IDLE;
                    end
                end
                else if (hit)
                begin
                    // found: write back the updated count
                    mem_we     = 1'b1;
                    state_next = mec_pkg::ST_IDLE;
                end
                else if (scan_end)
                begin
                    // absent: append, or drop when full
                    if (used_reg == FULL)
                    begin
                        ovf_seen_next = 1'b1;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = used_reg[IDX_W-1:0];
                        mem_wdata = {value_reg, new_count};
                        used_next = CNT_W'(used_reg + 1'b1);
                    end
                    state_next = mec_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mec_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mec_pkg::ST_IDLE;
            pend_valid_reg <= 1'b0;
            used_reg       <= '0;
            ovf_seen_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            used_reg       <= used_next;
            ovf_seen_reg   <= ovf_seen_next;
            done_reg       <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        value_reg    <= value_next;
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        equal_reg    <= equal_next;
        ovf_out_reg  <= ovf_out_next;
    end

    assign busy     = (state_reg != mec_pkg::ST_IDLE);
    assign done     = done_reg;
    assign equal    = equal_reg;
    assign overflow = ovf_out_reg;

endmodule

`default_nettype wire

FILE: rtl/mec_checker.sv
// ----------------------------------------------------------------------------
// mec_checker
// Port-level checks on the multiset equality counter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mec_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic [mec_pkg::KIND_W-1:0] kind,
    input wire logic                       done,
    input wire logic                       equal,
    input wire logic                       overflow
);

    // a result appears only once the block is free again
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while busy");

    // the result strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    // a check transaction always occupies the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == mec_pkg::KIND_CHECK)) |=> busy)
        else $error("check transaction did not start a scan");

    // an unused kind is dropped without effect
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == mec_pkg::KIND_NONE)) |=> (!busy && !done))
        else $error("unused kind was acted upon");

    // a dropped value never reports equal
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> !equal)
        else $error("equal reported with overflow");

endmodule

bind multiset_equality_counter_top mec_checker u_mec_checker (.*);

`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for multiset_equality_counter_top. A table of directed
// transactions covers the value extremes, every kind, count wraparound and a
// full table, then random add/remove sequence pairs with a closing check run
// against a local model of the value table. Check results are compared field
// by field, in order, as each done pulse arrives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import mec_pkg::*;

    localparam int DEPTH         = TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS  = 900;
    localparam int QUIET_TAIL    = 200;
    localparam int SETTLE_CYCLES = DEPTH + 8;

    typedef struct packed {
        logic equal;
        logic overflow;
    } verdict_t;

    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        int                 reps;
        int                 step;
        logic               has_verdict;
        verdict_t           verdict;
    } stim_row_t;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    kind_t              kind  = KIND_NONE;
    logic [VALUE_W-1:0] value = '0;
    logic               busy;
    logic               done;
    logic               equal;
    logic               overflow;

    // model of the value table
    logic [VALUE_W-1:0] tbl_vals   [DEPTH];
    logic [COUNT_W-1:0] tbl_counts [DEPTH];
    int                 tbl_fill    = 0;
    bit                 tbl_dropped = 1'b0;

    verdict_t  pending_verdicts [$];
    stim_row_t stim_plan [$];

    int  mismatches       = 0;
    int  verdicts_checked = 0;
    int  overflow_checks  = 0;
    int  useful_items     = 0;
    bit  idle_enabled     = 1'b1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    multiset_equality_counter_top #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .kind     (kind),
        .value    (value),
        .done     (done),
        .equal    (equal),
        .overflow (overflow)
    );

    // find or insert a value, then step its count up or down
    function automatic void tally_value(logic [VALUE_W-1:0] v, bit up);
        int slot;
        bit hit;
        int j;
        slot = tbl_fill;
        hit  = 1'b0;
        for (j = 0; j < tbl_fill; j++)
        begin
            if (!hit && tbl_vals[j] == v)
            begin
                slot = j;
                hit  = 1'b1;
            end
        end
        if (!hit)
        begin
            // full table: drop the new value and remember it
            if (tbl_fill >= DEPTH)
            begin
                tbl_dropped = 1'b1;
                return;
            end
            tbl_vals[slot]   = v;
            tbl_counts[slot] = '0;
            tbl_fill++;
        end
        tbl_counts[slot] = tbl_counts[slot] + (up ? COUNT_ONE : COUNT_MINUS);
    endfunction

    // verdict of a check, then clear the table and the sticky flag
    function automatic verdict_t check_and_clear();
        verdict_t r;
        bit       all_zero;
        int       j;
        all_zero = 1'b1;
        for (j = 0; j < tbl_fill; j++)
        begin
            if (tbl_counts[j] != '0)
                all_zero = 1'b0;
        end
        r.equal     = all_zero && !tbl_dropped;
        r.overflow  = tbl_dropped;
        tbl_fill    = 0;
        tbl_dropped = 1'b0;
        return r;
    endfunction

    // offer one transaction and wait until it is taken
    task automatic send_item(kind_t k, logic [VALUE_W-1:0] v, bit has_verdict,
                             verdict_t typed);
        verdict_t predicted;
        start <= 1'b1;
        kind  <= k;
        value <= v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (k != KIND_NONE)
            useful_items++;
        case (k)
            KIND_ADD:    tally_value(v, 1'b1);
            KIND_REMOVE: tally_value(v, 1'b0);
            KIND_CHECK:
            begin
                predicted = check_and_clear();
                if (predicted.overflow)
                    overflow_checks++;
                pending_verdicts.push_back(has_verdict ? typed : predicted);
            end
            default: ;
        endcase
    endtask

    // idle burst with junk on the payload
    task automatic maybe_idle();
        int n;
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 16);
            start <= 1'b0;
            kind  <= kind_t'($urandom_range(0, 3));
            value <= $urandom;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic plan_row(kind_t k, logic [VALUE_W-1:0] v, int reps, int step,
                            logic has_verdict, logic eq, logic ov);
        stim_row_t r;
        r.kind             = k;
        r.value            = v;
        r.reps             = reps;
        r.step             = step;
        r.has_verdict      = has_verdict;
        r.verdict.equal    = eq;
        r.verdict.overflow = ov;
        stim_plan.push_back(r);
    endtask

    // element value: small pool for repeats, extremes, or anything
    function automatic logic [VALUE_W-1:0] pick_value(logic [VALUE_W-1:0] base);
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000 + $urandom_range(0, 1);
            1:       return 32'h7FFF_FFFF - $urandom_range(0, 1);
            2:       return $urandom;
            default: return base + $urandom_range(0, 7);
        endcase
    endfunction

    // add/remove pair of sequences, interleaved, closed by a check
    task automatic run_sequence();
        logic [VALUE_W-1:0] firsts  [$];
        logic [VALUE_W-1:0] seconds [$];
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] tmp;
        verdict_t           none;
        int                 len;
        int                 mode;
        int                 i;
        int                 j;
        int                 ia;
        int                 ib;
        none = '0;
        base = $urandom;
        mode = $urandom_range(0, 47);
        if (mode < 4)
        begin
            // noise: random kinds, unused kind included
            len = $urandom_range(1, 8);
            for (i = 0; i < len; i++)
            begin
                maybe_idle();
                send_item(kind_t'($urandom_range(0, 3)), $urandom, 1'b0, none);
            end
            return;
        end
        if (mode < 8)
        begin
            // more distinct values than the table holds
            len = $urandom_range(DEPTH + 1, DEPTH + 12);
            for (i = 0; i < len; i++)
                firsts.push_back(base + i);
        end
        else if (mode == 8)
        begin
            // one value repeated around the count wrap
            len = $urandom_range(250, 262);
            for (i = 0; i < len; i++)
                firsts.push_back(base);
        end
        else
        begin
            len = $urandom_range(0, 24);
            for (i = 0; i < len; i++)
                firsts.push_back(pick_value(base));
        end
        seconds = firsts;
        for (i = seconds.size() - 1; i > 0; i--)
        begin
            j          = $urandom_range(0, i);
            tmp        = seconds[i];
            seconds[i] = seconds[j];
            seconds[j] = tmp;
        end
        // break the match now and then
        case ($urandom_range(0, 5))
            0: seconds.push_back(pick_value(base));
            1: if (seconds.size() != 0) void'(seconds.pop_back());
            2: if (seconds.size() != 0) seconds[0] = pick_value(base);
            default: ;
        endcase
        ia = 0;
        ib = 0;
        while (ia < firsts.size() || ib < seconds.size())
        begin
            maybe_idle();
            if (ib >= seconds.size() || (ia < firsts.size() && $urandom_range(0, 1)))
            begin
                send_item(KIND_ADD, firsts[ia], 1'b0, none);
                ia++;
            end
            else
            begin
                send_item(KIND_REMOVE, seconds[ib], 1'b0, none);
                ib++;
            end
        end
        maybe_idle();
        send_item(KIND_CHECK, $urandom, 1'b0, none);
        if ($urandom_range(0, 7) == 0)
            drain_results();
    endtask

    // result checker
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("unexpected result: equal=%0b overflow=%0b", equal, overflow);
                mismatches++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                verdicts_checked++;
                if (equal !== want.equal)
                begin
                    $error("equal: expected %0b, got %0b", want.equal, equal);
                    mismatches++;
                end
                if (overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b, got %0b", want.overflow, overflow);
                    mismatches++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        stim_row_t row;
        int        r;
        int        i;
        int        random_base;
        bit        no_typed;

        // check right after reset
        plan_row(KIND_CHECK,  32'h0000_0000, 1,   0, 1'b1, 1'b1, 1'b0);
        // value extremes cancel out
        plan_row(KIND_ADD,    32'h8000_0000, 1,   0, 1'b0, 1'b0, 1'b0);
        plan_row(KIND_REMOVE, 32'h8000_0000, 1,   0, 1'b0, 1'b0, 1'b0);
        plan_row(KIND_ADD,    32'h7FFF_FFFF, 1,   0, 1'b0, 1'b0, 1'b0);
        plan_row(KIND_REMOVE, 32'h7FFF_FFFF, 1,   0, 1'b0, 1'b0, 1'b0);
        plan_row(KIND_CHECK,  32'hFFFF_FFFF, 1,   0, 1'b1, 1'b1, 1'b0);
        // lone add, lone remove
        plan_row(KIND_ADD,    32'h0000_0000, 1,   0, 1'b0, 1'b0, 1'b0);
        plan_row(KIND_CHECK,  32'h0000_0000, 1,   0, 1'b1, 1'b0, 1'b0);
        plan_row(KIND_REMOVE, 32'hFFFF_FFFF, 1,   0, 1'b0, 1'b0, 1'b0);
        plan_row(KIND_CHECK,  32'h0000_0000, 1,   0, 1'b1, 1'b0, 1'b0);
        // unused kind leaves the table alone
        plan_row(KIND_NONE,   32'h0000_0005, 1,   0, 1'b0, 1'b0, 1'b0);
        plan_row(KIND_CHECK,  32'h0000_0000, 1,   0, 1'b1, 1'b1, 1'b0);
        // count wraps back to zero both ways
        plan_row(KIND_ADD,    32'h0000_002A, 256, 0, 1'b0, 1'b0, 1'b0);
        plan_row(KIND_REMOVE, 32'h0000_0009, 256, 0, 1'b0, 1'b0, 1'b0);
        plan_row(KIND_CHECK,  32'h0000_0000, 1,   0, 1'b1, 1'b1, 1'b0);
        // full table, then one distinct value too many
        plan_row(KIND_ADD,    32'h0000_03E8, DEPTH, 1, 1'b0, 1'b0, 1'b0);
        plan_row(KIND_NONE,   32'h0000_1388, 1,   0, 1'b0, 1'b0, 1'b0);
        plan_row(KIND_ADD,    32'h0000_1388, 1,   0, 1'b0, 1'b0, 1'b0);
        plan_row(KIND_REMOVE, 32'h0000_03E8, DEPTH, 1, 1'b0, 1'b0, 1'b0);
        plan_row(KIND_CHECK,  32'h0000_0000, 1,   0, 1'b1, 1'b0, 1'b1);
        // full table, known value still counted
        plan_row(KIND_ADD,    32'h0000_0001, DEPTH, 1, 1'b0, 1'b0, 1'b0);
        plan_row(KIND_REMOVE, 32'h0000_0001, DEPTH, 1, 1'b0, 1'b0, 1'b0);
        plan_row(KIND_ADD,    32'h0000_0001, 3,   0, 1'b0, 1'b0, 1'b0);
        plan_row(KIND_REMOVE, 32'h0000_0001, 2,   0, 1'b0, 1'b0, 1'b0);
        plan_row(KIND_CHECK,  32'h0000_0000, 1,   0, 1'b0, 1'b0, 1'b0);

        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (r = 0; r < stim_plan.size(); r++)
        begin
            row = stim_plan[r];
            for (i = 0; i < row.reps; i++)
            begin
                maybe_idle();
                no_typed = !(row.has_verdict && i == row.reps - 1);
                send_item(row.kind, row.value + VALUE_W'(i * row.step),
                          !no_typed, row.verdict);
            end
        end
        drain_results();

        // random sequences, quiet at the end
        random_base = useful_items;
        while (useful_items - random_base < RANDOM_ITEMS)
        begin
            if (useful_items - random_base >= RANDOM_ITEMS - QUIET_TAIL)
                idle_enabled = 1'b0;
            else if ($urandom_range(0, 3) == 0)
                idle_enabled = !idle_enabled;
            run_sequence();
        end

        // final check so no partial sequence is left open
        send_item(KIND_CHECK, $urandom, 1'b0, '0);
        start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_verdicts.size() != 0)
            mismatches++;
        $display("Ran %0d add/remove/check transactions, %0d check results compared",
                 useful_items, verdicts_checked);
        $display("(%0d with the table-full flag), count wraparound and unused kind included",
                 overflow_checks);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial
    begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
